### rtl/core/rmed_pkg.sv
// shared constants for the running median block
`default_nettype none
package rmed_pkg;
    localparam int DEF_CAPACITY = 1024;
    localparam int SAMPLE_W     = 32;
    localparam int MED_W        = 33;
    localparam logic signed [MED_W-1:0] MED_RESET = {1'b1, {(MED_W-1){1'b0}}};
endpackage
`default_nettype wire

### rtl/core/running_median_two_heaps_top.sv
// running median over two heaps kept in synchronous memories
// an insert takes up to three heap passes: a sift-down pop and a sift-up push that move
// the larger heap's top over, then a sift-up push of the sample into its target heap
// throughput: one sample at a time; the heap sift loop through one memory read port sets it
// a dropped sample (storage full) raises its result once the output register is free
// reset: heaps empty, median at twice the most negative sample; memories are not cleared
`default_nettype none
module running_median_two_heaps_top
    import rmed_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int HALF_CAP = (CAPACITY + 1) / 2,
    localparam int AW = (HALF_CAP > 1) ? $clog2(HALF_CAP) : 1,
    localparam int SW = $clog2(HALF_CAP + 1),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire signed [SAMPLE_W-1:0] i_sample,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic signed [MED_W-1:0]   o_median_doubled,
    output logic [CW-1:0]             o_sample_count,
    output logic                      o_full_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_U_CHK, S_U_D, S_P_LAST, S_P_LASTD, S_P_L, S_P_LD, S_P_RD
    } t_state;
    typedef enum logic [1:0] {PH_MOVE_POP, PH_MOVE_PUSH, PH_PUSH_S} t_phase;

    t_state r_state;
    t_phase r_phase;
    logic   r_fin;

    // heap 0 is the max-heap of the lower half, heap 1 the min-heap of the upper half
    logic [SAMPLE_W-1:0] lo_mem [HALF_CAP];
    logic [SAMPLE_W-1:0] up_mem [HALF_CAP];
    logic [SAMPLE_W-1:0] r_lo_rd, r_up_rd;

    logic                       r_hsel, r_tgt, r_eq, r_full;
    logic [SW-1:0]              r_idx, r_n, r_lo_sz, r_up_sz;
    logic signed [SAMPLE_W-1:0] r_val, r_cl, r_k, r_s, r_top_lo, r_top_up;
    logic signed [MED_W-1:0]    r_med;

    logic                       mem_we;
    logic [AW-1:0]              mem_addr;
    logic signed [SAMPLE_W-1:0] mem_wd, rd;
    logic [SW:0]                l_idx, r_idx2, n_ext;
    logic [SW-1:0]              p_idx, bi;
    logic signed [SAMPLE_W-1:0] bv;
    logic                       l_ok, r_ok, push_hi;
    logic [CW-1:0]              count;
    logic signed [MED_W-1:0]    s2;

    function automatic logic outranks(input logic signed [SAMPLE_W-1:0] a,
                                      input logic signed [SAMPLE_W-1:0] b,
                                      input logic is_min);
        outranks = is_min ? (a < b) : (a > b);
    endfunction

    assign rd      = r_hsel ? r_up_rd : r_lo_rd;
    assign l_idx   = {r_idx, 1'b1};
    assign r_idx2  = l_idx + (SW+1)'(1);
    assign n_ext   = {1'b0, r_n};
    assign p_idx   = (r_idx - SW'(1)) >> 1;
    assign l_ok    = l_idx < n_ext;
    assign r_ok    = r_idx2 < n_ext;
    assign count   = CW'(r_lo_sz) + CW'(r_up_sz);
    assign s2      = {i_sample, 1'b0};
    assign o_ready = (r_state == S_IDLE) && !r_fin;
    assign push_hi = outranks(r_val, rd, r_hsel);

    // best of hole value, left child and right child
    always_comb begin
        bv = r_val;
        bi = r_idx;
        if (outranks(r_cl, r_val, r_hsel)) begin
            bv = r_cl;
            bi = l_idx[SW-1:0];
        end
        if (r_ok && outranks(rd, bv, r_hsel)) begin
            bv = rd;
            bi = r_idx2[SW-1:0];
        end
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_idx[AW-1:0];
        mem_wd   = r_val;
        unique case (r_state)
            S_U_CHK: begin
                if (r_idx == '0) mem_we = 1'b1;
                else mem_addr = p_idx[AW-1:0];
            end
            S_U_D: begin
                mem_we = 1'b1;
                if (push_hi) mem_wd = rd;
            end
            S_P_LAST: mem_addr = r_n[AW-1:0];
            S_P_L: begin
                if (!l_ok) mem_we = 1'b1;
                else mem_addr = l_idx[AW-1:0];
            end
            S_P_LD: mem_addr = r_idx2[AW-1:0];
            S_P_RD: begin
                mem_we = 1'b1;
                mem_wd = bv;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && !r_hsel) lo_mem[mem_addr] <= mem_wd;
        if (mem_we && r_hsel) up_mem[mem_addr] <= mem_wd;
        r_lo_rd <= lo_mem[mem_addr];
        r_up_rd <= up_mem[mem_addr];
        if (mem_we && mem_addr == '0) begin
            if (r_hsel) r_top_up <= mem_wd;
            else r_top_lo <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_PUSH_S;
            r_fin   <= 1'b0;
            r_lo_sz <= '0;
            r_up_sz <= '0;
            r_med   <= MED_RESET;
            o_valid <= 1'b0;
        end else begin
            // a pending result refills the output register in the same cycle
            if (o_valid && i_ready && !r_fin) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (r_fin) begin
                        if (!o_valid || i_ready) begin
                            if (!r_full) begin
                                if (r_eq) begin
                                    o_median_doubled <= r_tgt ? {r_top_up, 1'b0}
                                                              : {r_top_lo, 1'b0};
                                    r_med <= r_tgt ? {r_top_up, 1'b0} : {r_top_lo, 1'b0};
                                end else begin
                                    o_median_doubled <= MED_W'(r_top_lo) + MED_W'(r_top_up);
                                    r_med <= MED_W'(r_top_lo) + MED_W'(r_top_up);
                                end
                            end else begin
                                o_median_doubled <= r_med;
                            end
                            o_sample_count <= count;
                            o_full_res     <= r_full;
                            o_valid        <= 1'b1;
                            r_fin          <= 1'b0;
                        end
                    end else if (i_valid) begin
                        r_s    <= i_sample;
                        r_full <= (32'(count) >= CAPACITY);
                        if (32'(count) >= CAPACITY) begin
                            r_fin <= 1'b1;
                        end else begin
                            r_tgt <= (s2 > r_med);
                            r_eq  <= (r_lo_sz == r_up_sz);
                            // target heap is the larger one: its top moves over first
                            if (r_lo_sz != r_up_sz &&
                                    ((s2 > r_med) == (r_up_sz > r_lo_sz))) begin
                                r_phase <= PH_MOVE_POP;
                                r_hsel  <= (s2 > r_med);
                                r_idx   <= '0;
                                r_state <= S_P_LAST;
                                if (s2 > r_med) begin
                                    r_up_sz <= r_up_sz - SW'(1);
                                    r_n     <= r_up_sz - SW'(1);
                                    r_k     <= r_top_up;
                                end else begin
                                    r_lo_sz <= r_lo_sz - SW'(1);
                                    r_n     <= r_lo_sz - SW'(1);
                                    r_k     <= r_top_lo;
                                end
                            end else begin
                                r_phase <= PH_PUSH_S;
                                r_hsel  <= (s2 > r_med);
                                r_val   <= i_sample;
                                r_state <= S_U_CHK;
                                if (s2 > r_med) begin
                                    r_idx   <= r_up_sz;
                                    r_up_sz <= r_up_sz + SW'(1);
                                end else begin
                                    r_idx   <= r_lo_sz;
                                    r_lo_sz <= r_lo_sz + SW'(1);
                                end
                            end
                        end
                    end
                end
                S_U_CHK: begin
                    if (r_idx != '0) r_state <= S_U_D;
                end
                S_U_D: begin
                    if (push_hi) begin
                        r_idx   <= p_idx;
                        r_state <= S_U_CHK;
                    end
                end
                S_P_LAST: r_state <= S_P_LASTD;
                S_P_LASTD: begin
                    r_val   <= rd;
                    r_state <= S_P_L;
                end
                S_P_L: begin
                    if (l_ok) r_state <= S_P_LD;
                end
                S_P_LD: begin
                    r_cl    <= rd;
                    r_state <= S_P_RD;
                end
                S_P_RD: begin
                    if (bi != r_idx) begin
                        r_idx   <= bi;
                        r_state <= S_P_L;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // sequencing between heap passes
            if ((r_state == S_U_CHK && r_idx == '0) || (r_state == S_U_D && !push_hi)) begin
                if (r_phase == PH_MOVE_PUSH) begin
                    r_phase <= PH_PUSH_S;
                    r_hsel  <= r_tgt;
                    r_val   <= r_s;
                    r_state <= S_U_CHK;
                    if (r_tgt) begin
                        r_idx   <= r_up_sz;
                        r_up_sz <= r_up_sz + SW'(1);
                    end else begin
                        r_idx   <= r_lo_sz;
                        r_lo_sz <= r_lo_sz + SW'(1);
                    end
                end else begin
                    r_fin   <= 1'b1;
                    r_state <= S_IDLE;
                end
            end
            if ((r_state == S_P_L && !l_ok) || (r_state == S_P_RD && bi == r_idx)) begin
                r_phase <= PH_MOVE_PUSH;
                r_hsel  <= !r_tgt;
                r_val   <= r_k;
                r_state <= S_U_CHK;
                if (r_tgt) begin
                    r_idx   <= r_lo_sz;
                    r_lo_sz <= r_lo_sz + SW'(1);
                end else begin
                    r_idx   <= r_up_sz;
                    r_up_sz <= r_up_sz + SW'(1);
                end
            end
        end
    end

`ifndef SYNTH
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_lo_sz <= r_up_sz + SW'(1)) && (r_up_sz <= r_lo_sz + SW'(1))))
        else $error("heap sizes out of balance");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(count) <= CAPACITY)
        else $error("sample count above capacity");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_fin || r_state != S_IDLE))
        else $error("accepted sample produced no pending result");
`endif
endmodule
`default_nettype wire

### sim/tb_running_median_two_heaps_top.sv
// testbench for the running median block: random and directed samples checked against a heap model
`default_nettype none
module tb_running_median_two_heaps_top;
    import rmed_pkg::*;

    localparam int CAP      = 1024;
    localparam int HALF     = (CAP + 1) / 2;
    localparam int CW       = $clog2(CAP + 1);
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic signed [MED_W-1:0] med;
        logic [CW-1:0]           cnt;
        logic                    full;
    } median_res_t;

    // heap-based median predictor and queue of expected results
    class median_scoreboard;
        logic signed [31:0] lo_heap [HALF];
        logic signed [31:0] hi_heap [HALF];
        int unsigned lo_n, hi_n;
        logic signed [MED_W-1:0] med2;
        median_res_t pending [$];
        int errors;

        function void clear();
            lo_n = 0;
            hi_n = 0;
            med2 = MED_RESET;
            pending.delete();
            errors = 0;
        endfunction

        // is_max selects the lower (max) heap
        function void push(bit is_max, logic signed [31:0] v);
            int unsigned i, p;
            logic signed [31:0] t;
            i = is_max ? lo_n : hi_n;
            if (is_max) begin
                lo_heap[i] = v;
                lo_n++;
            end else begin
                hi_heap[i] = v;
                hi_n++;
            end
            while (i > 0) begin
                p = (i - 1) / 2;
                if (is_max) begin
                    if (!(lo_heap[i] > lo_heap[p])) break;
                    t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
                end else begin
                    if (!(hi_heap[i] < hi_heap[p])) break;
                    t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
                end
                i = p;
            end
        endfunction

        function logic signed [31:0] pop(bit is_max);
            logic signed [31:0] top, t;
            int unsigned n, i, l, r, b;
            n = is_max ? lo_n : hi_n;
            top = is_max ? lo_heap[0] : hi_heap[0];
            n--;
            if (is_max) begin
                lo_heap[0] = lo_heap[n];
                lo_n = n;
            end else begin
                hi_heap[0] = hi_heap[n];
                hi_n = n;
            end
            i = 0;
            forever begin
                l = 2 * i + 1;
                r = l + 1;
                b = i;
                if (is_max) begin
                    if (l < n && lo_heap[l] > lo_heap[b]) b = l;
                    if (r < n && lo_heap[r] > lo_heap[b]) b = r;
                    if (b == i) break;
                    t = lo_heap[i]; lo_heap[i] = lo_heap[b]; lo_heap[b] = t;
                end else begin
                    if (l < n && hi_heap[l] < hi_heap[b]) b = l;
                    if (r < n && hi_heap[r] < hi_heap[b]) b = r;
                    if (b == i) break;
                    t = hi_heap[i]; hi_heap[i] = hi_heap[b]; hi_heap[b] = t;
                end
                i = b;
            end
            return top;
        endfunction

        function void note_sample(logic signed [31:0] s);
            median_res_t r;
            bit up;
            r.full = 1'b0;
            if (lo_n + hi_n >= CAP) begin
                r.full = 1'b1;
            end else begin
                up = ($signed({s, 1'b0}) > med2);
                if (lo_n == hi_n) begin
                    push(!up, s);
                    med2 = up ? {hi_heap[0], 1'b0} : {lo_heap[0], 1'b0};
                end else begin
                    if (lo_n < hi_n) begin
                        if (up) begin
                            push(1'b1, pop(1'b0));
                            push(1'b0, s);
                        end else begin
                            push(1'b1, s);
                        end
                    end else begin
                        if (up) begin
                            push(1'b0, s);
                        end else begin
                            push(1'b0, pop(1'b1));
                            push(1'b1, s);
                        end
                    end
                    med2 = MED_W'(lo_heap[0]) + MED_W'(hi_heap[0]);
                end
            end
            r.med = med2;
            r.cnt = CW'(lo_n + hi_n);
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [MED_W-1:0] med, logic [CW-1:0] cnt,
                                   logic full);
            median_res_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result med=%0d cnt=%0d full=%0b",
                         $time, med, cnt, full);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (med !== e.med) begin
                $display("%0t: median_doubled expected %0d actual %0d", $time, e.med, med);
                errors++;
            end
            if (cnt !== e.cnt) begin
                $display("%0t: sample_count expected %0d actual %0d", $time, e.cnt, cnt);
                errors++;
            end
            if (full !== e.full) begin
                $display("%0t: full_res expected %0b actual %0b", $time, e.full, full);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic signed [31:0]      i_sample = '0;
    logic                    i_ready = 1'b0;
    wire                     o_ready;
    wire                     o_valid;
    wire signed [MED_W-1:0]  o_median_doubled;
    wire [CW-1:0]            o_sample_count;
    wire                     o_full_res;

    median_scoreboard sb = new();
    bit               quiet = 1'b0;
    int               stall_cycles = 0;

    running_median_two_heaps_top #(.CAPACITY(CAP)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_sample(i_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_median_doubled(o_median_doubled), .o_sample_count(o_sample_count),
        .o_full_res(o_full_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each transfer, stall the receiver in bursts
    always @(posedge i_clk) begin
        int burst;
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_median_doubled, o_sample_count, o_full_res);
            if (burst > 0) begin
                burst--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WD_LIMIT) begin
            $display("tb_running_median_two_heaps_top failed");
            $finish;
        end
    end

    // valid stays up between back-to-back transfers and drops only for a gap
    task automatic send_sample(logic signed [31:0] s);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s);
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 40)) - 20;
            2: return $urandom_range(0, 1) ? 32'sh7fff_fff0 + $urandom_range(0, 15)
                                           : 32'sh8000_0000 + $urandom_range(0, 15);
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    initial begin
        int n;
        sb.clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, ties, equal to the reset median
        send_sample(32'sh8000_0000);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(0);
        send_sample(32'sh5555_5555);
        send_sample(32'shaaaa_aaaa);
        send_sample(-1);
        // fill storage, then keep sending dropped samples
        n = 12;
        while (n < CAP + 16) begin
            if (n > CAP - 40) quiet = 1'b1;
            send_sample(rand_sample());
            n++;
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_running_median_two_heaps_top passed");
        else
            $display("tb_running_median_two_heaps_top failed");
        $finish;
    end
endmodule
`default_nettype wire
